@@ design/integer_to_ascii_base_n_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the radix conversion core
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_BASE_N_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_BASE_N_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ITOA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("itoa core assertion failed");
// The expression must never be true outside reset.
`define ITOA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("itoa core forbidden condition seen");
`else
`define ITOA_ASSERT(lbl, clk, rst_n, prop)
`define ITOA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ design/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix conversion package
// Shared constants, controller types and the digit to ASCII mapping.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned VALUE_BITS_DEF  = 16;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] LETTER_GAP = 7'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_READ,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic push;
    logic pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic quot_zero;
    logic stack_empty;
  } sts_t;

  function automatic logic [CHAR_W-1:0] to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'(d) + CHAR_ZERO;
    if (c > CHAR_NINE) begin
      c = c + LETTER_GAP;
    end
    return c;
  endfunction

endpackage

@@ design/integer_to_ascii_base_n_core.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII radix conversion core
// Converts an unsigned value to its digits in the configured base, MSD first.
// ----------------------------------------------------------------------------
// Digits are computed into a stack, then popped and emitted; one item at a time.
// The bit-serial divider produces one quotient bit per cycle.
// Reset: asynchronous, active low; base returns to 10, the block to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_base_n_core #(
  parameter int unsigned VALUE_BITS  = itoa_pkg::VALUE_BITS_DEF,
  parameter int unsigned STACK_DEPTH = itoa_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [itoa_pkg::RADIX_W-1:0] radix_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [VALUE_BITS-1:0]        value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [itoa_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                         last_digit_o
);
  import itoa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  itoa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .last_digit_o (last_digit_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  itoa_dp #(
    .VALUE_BITS  (VALUE_BITS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .radix_i      (radix_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .digit_char_o (digit_char_o)
  );

endmodule

@@ design/itoa_dp.sv @@
// ----------------------------------------------------------------------------
// Radix conversion datapath
// Radix register, bit-serial restoring divider and the digit stack memory.
// ----------------------------------------------------------------------------
module itoa_dp #(
  parameter int unsigned VALUE_BITS  = itoa_pkg::VALUE_BITS_DEF,
  parameter int unsigned STACK_DEPTH = itoa_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [itoa_pkg::RADIX_W-1:0]  radix_i,
  input  logic [VALUE_BITS-1:0]         value_i,
  input  itoa_pkg::cmd_t                cmd_i,
  output itoa_pkg::sts_t                sts_o,
  output logic [itoa_pkg::CHAR_W-1:0]   digit_char_o
);
  import itoa_pkg::*;

  localparam int unsigned BIT_CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [RADIX_W-1:0]    radix_q, radix_d;
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [RADIX_W-1:0]    rd_q;
  logic [RADIX_W-1:0]    stack_mem [STACK_DEPTH];

  logic [RADIX_W:0]      trial;
  logic                  trial_ge;
  logic                  stack_full;
  logic [CNT_W-1:0]      count_dec;

  // Writes are clamped into the supported range of bases.
  always_comb begin
    radix_d = radix_q;
    if (cfg_we_i) begin
      if (radix_i < RADIX_MIN) begin
        radix_d = RADIX_MIN;
      end else if (radix_i > RADIX_MAX) begin
        radix_d = RADIX_MAX;
      end else begin
        radix_d = radix_i;
      end
    end
  end

  // One restoring division step: shift in the next dividend bit, subtract
  // the base when it fits and shift the quotient bit into the dividend.
  assign trial      = {rem_q, quot_q[VALUE_BITS-1]};
  assign trial_ge   = (trial >= {1'b0, radix_q});
  assign stack_full = (count_q == CNT_W'(STACK_DEPTH));
  assign count_dec  = count_q - CNT_W'(1);

  always_comb begin
    quot_d    = quot_q;
    rem_d     = rem_q;
    bit_cnt_d = bit_cnt_q;
    count_d   = count_q;
    if (cmd_i.load) begin
      quot_d    = value_i;
      rem_d     = '0;
      bit_cnt_d = '0;
      count_d   = '0;
    end else if (cmd_i.step) begin
      quot_d    = {quot_q[VALUE_BITS-2:0], trial_ge};
      rem_d     = trial_ge ? RADIX_W'(trial - {1'b0, radix_q}) : trial[RADIX_W-1:0];
      bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
    end else if (cmd_i.push) begin
      rem_d     = '0;
      bit_cnt_d = '0;
      if (!stack_full) begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      count_d = count_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q   <= RADIX_RESET;
      quot_q    <= '0;
      rem_q     <= '0;
      bit_cnt_q <= '0;
      count_q   <= '0;
    end else begin
      radix_q   <= radix_d;
      quot_q    <= quot_d;
      rem_q     <= rem_d;
      bit_cnt_q <= bit_cnt_d;
      count_q   <= count_d;
    end
  end

  // Digit stack: pushes beyond the depth are dropped.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !stack_full) begin
      stack_mem[count_q[IDX_W-1:0]] <= rem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      rd_q <= stack_mem[count_dec[IDX_W-1:0]];
    end
  end

  assign sts_o.div_done    = (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1));
  assign sts_o.quot_zero   = (quot_q == '0);
  assign sts_o.stack_empty = (count_q == '0);
  assign digit_char_o      = to_char(rd_q);

endmodule

@@ design/itoa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Radix conversion controller
// Sequences loading, serial division, digit pushes and digit output.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_base_n_core_assert.svh"

module itoa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           last_digit_o,
  input  itoa_pkg::sts_t sts_i,
  output itoa_pkg::cmd_t cmd_o
);
  import itoa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    last_digit_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // A zero quotient ends the division loop; at least one digit exists.
        cmd_o.push = 1'b1;
        state_d    = sts_i.quot_zero ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        cmd_o.pop = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o  = 1'b1;
        last_digit_o = sts_i.stack_empty;
        if (out_ready_i) begin
          state_d = sts_i.stack_empty ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ITOA_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, cmd_o.pop && sts_i.stack_empty)
  `ITOA_ASSERT_NEVER(a_busy_overlap, clk_i, rst_ni, in_ready_o && out_valid_o)
  `ITOA_ASSERT(a_last_to_idle, clk_i, rst_ni, out_valid_o && out_ready_i && last_digit_o |=> in_ready_o)
  `ITOA_ASSERT(a_push_after_div, clk_i, rst_ni, cmd_o.push |-> $past(cmd_o.step))

endmodule
